>>> sv/cu2x_pkg.sv
// Shared types, constants and the interpolation filter of the chroma upsampler.
`default_nettype none

package cu2x_pkg;

  localparam int SmpW    = 8;   // chroma sample width
  localparam int ValW    = 10;  // filtered output width, two's complement
  localparam int PosOutW = 9;   // output position width
  localparam int LenW    = 9;   // line length register width

  localparam logic [LenW-1:0] LineLenReset = 9'd88;

  // Filter weights and rounding.
  localparam logic signed [17:0] WNear    = 18'sd111;
  localparam logic signed [17:0] WMid     = 18'sd29;
  localparam logic signed [17:0] WEdgeA   = 18'sd3;
  localparam logic signed [17:0] WEdgeB   = 18'sd9;
  localparam logic signed [17:0] RoundAdd = 18'sd64;
  localparam int                 FracBits = 7;

  // Number of outputs one sample releases, before negative positions are dropped.
  localparam logic [2:0] RunNormal = 3'd2;
  localparam logic [2:0] RunLast   = 3'd5;

  typedef struct packed {
    logic fill;   // load the external value
    logic shift;  // take the neighbor's value
  } cu2x_cell_ctrl_t;

  typedef struct packed {
    logic load;   // a new sample was accepted
    logic last;   // that sample closes the line
  } cu2x_load_t;

  // Weights -3, 29, 111, -9 on p, q, r, s; the odd phase passes the taps reversed.
  function automatic logic signed [ValW-1:0] filt_even(
    input logic [SmpW-1:0] p,
    input logic [SmpW-1:0] q,
    input logic [SmpW-1:0] r,
    input logic [SmpW-1:0] s
  );
    logic signed [17:0] acc;
    acc = WMid * $signed({10'b0, q}) + WNear * $signed({10'b0, r})
        - WEdgeA * $signed({10'b0, p}) - WEdgeB * $signed({10'b0, s}) + RoundAdd;
    return ValW'(acc >>> FracBits);
  endfunction

endpackage

`default_nettype wire

>>> sv/cu2x_cell.sv
// One sample cell of a shifting window: loads a value or takes its neighbor's.
`default_nettype none

module cu2x_cell (
  input  wire logic                      clk_i,
  input  wire cu2x_pkg::cu2x_cell_ctrl_t ctrl_i,
  input  wire logic [cu2x_pkg::SmpW-1:0] fill_i,
  input  wire logic [cu2x_pkg::SmpW-1:0] neigh_i,
  output logic      [cu2x_pkg::SmpW-1:0] smp_o
);
  import cu2x_pkg::*;

  logic [SmpW-1:0] smp_d, smp_q;

  always_comb begin
    smp_d = smp_q;
    if (ctrl_i.fill) begin
      smp_d = fill_i;
    end else if (ctrl_i.shift) begin
      smp_d = neigh_i;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q <= smp_d;
  end

  assign smp_o = smp_q;

endmodule

`default_nettype wire

>>> sv/cu2x_emit.sv
// Output sequencer: holds one sample's taps and issues its results one per cycle while the receiver keeps up.
`default_nettype none

module cu2x_emit #(
  parameter int PosW = 10
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire cu2x_pkg::cu2x_load_t               ld_i,
  input  wire logic [3:0][cu2x_pkg::SmpW-1:0]     ld_smp_i,
  input  wire logic signed [PosW-1:0]             ld_pos_i,
  output logic                                    ld_ready_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [cu2x_pkg::ValW-1:0]        upsampled_value_o,
  output logic        [cu2x_pkg::PosOutW-1:0]     out_position_o,
  output logic                                    run_last_o,
  output logic                                    line_done_o
);
  import cu2x_pkg::*;

  logic [SmpW-1:0] tap [4];
  cu2x_cell_ctrl_t tap_ctrl;

  logic                   job_vld_d, job_vld_q;
  logic                   odd_d, odd_q;
  logic                   last_d, last_q;
  logic [2:0]             rem_d, rem_q;
  logic signed [PosW-1:0] pos_d, pos_q;

  logic                   out_vld_d, out_vld_q;
  logic signed [ValW-1:0] val_d, val_q;
  logic [PosOutW-1:0]     opos_d, opos_q;
  logic                   rlast_d, rlast_q;
  logic                   done_d, done_q;

  logic step, fin, emit;
  logic signed [ValW-1:0] cur_val;

  // The tap window shifts left after each even position, emitted or dropped; the end cell repeats the edge sample.
  for (genvar i = 0; i < 4; i++) begin : g_tap
    logic [SmpW-1:0] nb;
    if (i < 3) begin : g_mid
      assign nb = tap[i+1];
    end else begin : g_end
      assign nb = tap[3];
    end
    cu2x_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (tap_ctrl),
      .fill_i  (ld_smp_i[i]),
      .neigh_i (nb),
      .smp_o   (tap[i])
    );
  end

  assign step       = job_vld_q && (!out_vld_q || out_ready_i);
  assign fin        = step && (rem_q == 3'd1);
  assign emit       = step && !pos_q[PosW-1];
  assign ld_ready_o = !job_vld_q || fin;

  assign tap_ctrl.fill  = ld_i.load;
  assign tap_ctrl.shift = step && !odd_q && !ld_i.load;

  assign cur_val = odd_q ? filt_even(tap[3], tap[2], tap[1], tap[0])
                         : filt_even(tap[0], tap[1], tap[2], tap[3]);

  always_comb begin
    job_vld_d = job_vld_q;
    odd_d     = odd_q;
    last_d    = last_q;
    rem_d     = rem_q;
    pos_d     = pos_q;
    if (step) begin
      odd_d = !odd_q;
      rem_d = rem_q - 3'd1;
      pos_d = pos_q + PosW'(1);
      if (fin) begin
        job_vld_d = 1'b0;
      end
    end
    if (ld_i.load) begin
      job_vld_d = 1'b1;
      odd_d     = 1'b1;
      last_d    = ld_i.last;
      rem_d     = ld_i.last ? RunLast : RunNormal;
      pos_d     = ld_pos_i;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q && !out_ready_i;
    val_d     = val_q;
    opos_d    = opos_q;
    rlast_d   = rlast_q;
    done_d    = done_q;
    if (emit) begin
      out_vld_d = 1'b1;
      val_d     = cur_val;
      opos_d    = PosOutW'($unsigned(pos_q));
      rlast_d   = (rem_q == 3'd1);
      done_d    = last_q && (rem_q == 3'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      job_vld_q <= job_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    odd_q   <= odd_d;
    last_q  <= last_d;
    rem_q   <= rem_d;
    pos_q   <= pos_d;
    val_q   <= val_d;
    opos_q  <= opos_d;
    rlast_q <= rlast_d;
    done_q  <= done_d;
  end

  assign out_valid_o       = out_vld_q;
  assign upsampled_value_o = val_q;
  assign out_position_o    = opos_q;
  assign run_last_o        = rlast_q;
  assign line_done_o       = done_q;

  a_rem_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_vld_q |-> rem_q != 3'd0)
    else $error("active job with no outputs left");

  a_done_is_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && done_q |-> rlast_q)
    else $error("line end result not flagged as the last of its transaction");

  a_job_retires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin && !ld_i.load |=> !job_vld_q)
    else $error("finished job still active");

endmodule

`default_nettype wire

>>> sv/chroma_upsample_2x_4tap.sv
// Top level of the 2x chroma line upsampler with a four-tap interpolating filter.
//
// Input channel (in_valid_i/in_ready_o) carries one 8-bit chroma sample per
// transaction, with line_end_i set on the final sample of a line. A line also
// ends on the sample whose index reaches the configured length less one.
// Output channel (out_valid_o/out_ready_i) carries one filtered sample per
// transaction, with its position in the doubled line, a flag on the last result
// of each input, and a flag on the final output of the line.
// Each input sample yields two results (the first samples of a line fewer,
// since negative positions are dropped) and the closing sample yields up to five.
// The output sequencer issues one result or one dropped position per cycle while
// the receiver keeps up. The first result of a sample passes through the job
// registers and then the output register, behind any dropped positions ahead of
// it.
// The configuration channel writes the line length; write it only while idle.
// Reset clears the window index, the pending job and the output register, and
// sets the line length to 88. When the receiver stalls, the current result holds
// and the input channel stops once the pending job cannot advance.
`default_nettype none

module chroma_upsample_2x_4tap #(
  parameter int MAX_LINE = 256
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [cu2x_pkg::LenW-1:0]        cfg_line_length_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [cu2x_pkg::SmpW-1:0]        chroma_sample_i,
  input  wire logic                             line_end_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic signed [cu2x_pkg::ValW-1:0]      upsampled_value_o,
  output logic        [cu2x_pkg::PosOutW-1:0]   out_position_o,
  output logic                                  run_last_o,
  output logic                                  line_done_o
);
  import cu2x_pkg::*;

  localparam int IdxW = $clog2(MAX_LINE);
  localparam int PosW = IdxW + 2;
  localparam int CmpW = (IdxW + 1 > LenW + 1) ? IdxW + 1 : LenW + 1;

  logic [LenW-1:0] len_d, len_q;
  logic [IdxW-1:0] idx_d, idx_q;

  logic [SmpW-1:0]       win [4];
  logic [3:0][SmpW-1:0]  nwin;
  cu2x_cell_ctrl_t       win_ctrl;
  cu2x_load_t            ld;
  logic signed [PosW-1:0] ld_pos;

  logic            in_acc, last, ld_ready;
  logic [CmpW-1:0] eff_len;

  // Input window: the first sample of a line fills every cell, later ones shift in.
  for (genvar i = 0; i < 4; i++) begin : g_win
    logic [SmpW-1:0] nb;
    if (i < 3) begin : g_mid
      assign nb = win[i+1];
    end else begin : g_end
      assign nb = chroma_sample_i;
    end
    cu2x_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (win_ctrl),
      .fill_i  (chroma_sample_i),
      .neigh_i (nb),
      .smp_o   (win[i])
    );
    assign nwin[i] = (idx_q == '0) ? chroma_sample_i : nb;
  end

  always_comb begin
    eff_len = CmpW'(len_q);
    if (len_q == '0) begin
      eff_len = CmpW'(1);
    end else if (CmpW'(len_q) > CmpW'(MAX_LINE)) begin
      eff_len = CmpW'(MAX_LINE);
    end
  end

  assign in_ready_o = ld_ready;
  assign in_acc     = in_valid_i && in_ready_o;
  assign last       = line_end_i || (CmpW'(idx_q) + CmpW'(1) >= eff_len);

  assign win_ctrl.fill  = in_acc && (idx_q == '0);
  assign win_ctrl.shift = in_acc && (idx_q != '0);

  assign ld.load = in_acc;
  assign ld.last = last;
  // First position released by sample k is 2k-3.
  assign ld_pos  = $signed({1'b0, idx_q, 1'b0}) - PosW'(3);

  assign cfg_ready_o = 1'b1;

  always_comb begin
    len_d = len_q;
    idx_d = idx_q;
    if (cfg_valid_i && cfg_ready_o) begin
      len_d = cfg_line_length_i;
    end
    if (in_acc) begin
      idx_d = last ? '0 : idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LineLenReset;
      idx_q <= '0;
    end else begin
      len_q <= len_d;
      idx_q <= idx_d;
    end
  end

  cu2x_emit #(
    .PosW (PosW)
  ) u_emit (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ld_i              (ld),
    .ld_smp_i          (nwin),
    .ld_pos_i          (ld_pos),
    .ld_ready_o        (ld_ready),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .upsampled_value_o (upsampled_value_o),
    .out_position_o    (out_position_o),
    .run_last_o        (run_last_o),
    .line_done_o       (line_done_o)
  );

  a_line_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last |=> idx_q == '0)
    else $error("index not cleared after the closing sample of a line");

  a_index_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !last |=> idx_q == $past(idx_q) + IdxW'(1))
    else $error("index did not advance by one inside a line");

  a_window_takes_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> win[3] == $past(chroma_sample_i))
    else $error("newest window cell does not hold the accepted sample");

endmodule

`default_nettype wire
